/* rtl/adsr_pkg.sv */
package adsr_pkg;

    // field widths fixed by the interface
    localparam int RATE_BITS      = 16;
    localparam int DT_BITS        = 16;
    localparam int PROD_BITS      = RATE_BITS + DT_BITS;
    localparam int LEVEL_OUT_BITS = 16;
    localparam int PHASE_BITS     = 2;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK_RATE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_RATE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUSTAIN_LEVEL = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_RATE  = 2'd3;

    // register reset values
    localparam logic [RATE_BITS-1:0] RST_ATTACK_RATE   = 16'd1310;
    localparam logic [RATE_BITS-1:0] RST_DECAY_RATE    = 16'd65;
    localparam logic [RATE_BITS-1:0] RST_SUSTAIN_LEVEL = 16'd39318;
    localparam logic [RATE_BITS-1:0] RST_RELEASE_RATE  = 16'd262;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_GATE = 1'b1;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [RATE_BITS-1:0] attack_rate;
        logic [RATE_BITS-1:0] decay_rate;
        logic [RATE_BITS-1:0] sustain_level;
        logic [RATE_BITS-1:0] release_rate;
    } cfg_t;

    typedef struct packed {
        logic               command;
        logic               gate_on;
        logic [DT_BITS-1:0] elapsed;
    } evt_t;

endpackage

/* rtl/adsr_cfg.sv */
module adsr_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [adsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output adsr_pkg::cfg_t                        cfg
);

    adsr_pkg::cfg_t cfg_reg;
    adsr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                adsr_pkg::CFG_ATTACK_RATE:   cfg_next.attack_rate   = cfg_data;
                adsr_pkg::CFG_DECAY_RATE:    cfg_next.decay_rate    = cfg_data;
                adsr_pkg::CFG_SUSTAIN_LEVEL: cfg_next.sustain_level = cfg_data;
                adsr_pkg::CFG_RELEASE_RATE:  cfg_next.release_rate  = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_rate   <= adsr_pkg::RST_ATTACK_RATE;
            cfg_reg.decay_rate    <= adsr_pkg::RST_DECAY_RATE;
            cfg_reg.sustain_level <= adsr_pkg::RST_SUSTAIN_LEVEL;
            cfg_reg.release_rate  <= adsr_pkg::RST_RELEASE_RATE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/adsr_step.sv */
module adsr_step #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd,
    input  adsr_pkg::evt_t        ev,
    input  adsr_pkg::cfg_t        cfg,
    output logic [LEVEL_BITS-1:0] level,
    output adsr_pkg::phase_t      phase
);

    // compare width: room for a level or a product plus one carry bit
    localparam int W  = (LEVEL_BITS > adsr_pkg::PROD_BITS) ? LEVEL_BITS
                                                           : adsr_pkg::PROD_BITS;
    localparam int CW = W + 1;

    logic [LEVEL_BITS-1:0]               level_reg;
    logic [LEVEL_BITS-1:0]               level_next;
    adsr_pkg::phase_t                    phase_reg;
    adsr_pkg::phase_t                    phase_next;

    logic [adsr_pkg::RATE_BITS-1:0]      rate;
    logic [adsr_pkg::PROD_BITS-1:0]      prod;
    logic [CW-1:0]                       full_w;
    logic [CW-1:0]                       sus_w;
    logic [CW-1:0]                       sus_cl;
    logic [CW-1:0]                       lvl_w;
    logic [CW-1:0]                       prod_w;
    logic [CW-1:0]                       lvl_plus;
    logic [CW-1:0]                       sus_plus;
    logic [CW-1:0]                       lvl_minus;

    // one multiplier, rate picked by the current phase
    always_comb
    begin
        unique case (phase_reg)
            adsr_pkg::PH_ATTACK:  rate = cfg.attack_rate;
            adsr_pkg::PH_DECAY:   rate = cfg.decay_rate;
            adsr_pkg::PH_SUSTAIN: rate = cfg.decay_rate;
            adsr_pkg::PH_RELEASE: rate = cfg.release_rate;
            default:              rate = cfg.release_rate;
        endcase
    end

    assign prod   = adsr_pkg::PROD_BITS'(rate) * adsr_pkg::PROD_BITS'(ev.elapsed);
    assign full_w = CW'({LEVEL_BITS{1'b1}});
    assign sus_w  = CW'(cfg.sustain_level);
    assign sus_cl = (sus_w > full_w) ? full_w : sus_w;
    assign lvl_w  = CW'(level_reg);
    assign prod_w = CW'(prod);

    assign lvl_plus  = lvl_w + prod_w;
    assign sus_plus  = sus_cl + prod_w;
    assign lvl_minus = lvl_w - prod_w;

    always_comb
    begin
        level_next = level_reg;
        phase_next = phase_reg;
        if (ev.command == adsr_pkg::CMD_GATE)
        begin
            phase_next = ev.gate_on ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_RELEASE;
        end
        else
        begin
            unique case (phase_reg)
                adsr_pkg::PH_ATTACK:
                begin
                    if (lvl_plus >= full_w)
                    begin
                        level_next = LEVEL_BITS'(full_w);
                        phase_next = adsr_pkg::PH_DECAY;
                    end
                    else
                    begin
                        level_next = LEVEL_BITS'(lvl_plus);
                    end
                end
                adsr_pkg::PH_DECAY:
                begin
                    // at or below sustain plus the step: land on sustain
                    if (lvl_w <= sus_plus)
                    begin
                        level_next = LEVEL_BITS'(sus_cl);
                        phase_next = adsr_pkg::PH_SUSTAIN;
                    end
                    else
                    begin
                        level_next = LEVEL_BITS'(lvl_minus);
                    end
                end
                adsr_pkg::PH_SUSTAIN:
                begin
                    level_next = LEVEL_BITS'(sus_cl);
                end
                adsr_pkg::PH_RELEASE:
                begin
                    if (lvl_w <= prod_w)
                        level_next = '0;
                    else
                        level_next = LEVEL_BITS'(lvl_minus);
                end
                default:
                begin
                    level_next = level_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            phase_reg <= adsr_pkg::PH_RELEASE;
        end
        else if (upd)
        begin
            level_reg <= level_next;
            phase_reg <= phase_next;
        end
    end

    assign level = level_reg;
    assign phase = phase_reg;

    // a gate word moves only the phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd && ev.command == adsr_pkg::CMD_GATE) |=> $stable(level_reg))
        else $error("gate word changed the level");

    // attack never lowers the level
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd && ev.command == adsr_pkg::CMD_TICK && phase_reg == adsr_pkg::PH_ATTACK)
        |=> (level_reg >= $past(level_reg)))
        else $error("attack lowered the level");

    // release never raises the level
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd && ev.command == adsr_pkg::CMD_TICK && phase_reg == adsr_pkg::PH_RELEASE)
        |=> (level_reg <= $past(level_reg) && phase_reg == adsr_pkg::PH_RELEASE))
        else $error("release raised the level or left release");

endmodule

/* rtl/adsr_envelope_generator.sv */
// ADSR envelope generator with a 16-bit level output. Each input word is a
// gate change (command 1: gate_on high starts attack, low starts release, the
// level is kept) or a time tick (command 0) whose elapsed count advances the
// current phase by rate*elapsed: attack saturates at full scale and goes to
// decay, decay clamps at the sustain level and goes to sustain, sustain holds
// the sustain level, release floors at zero. Every input word returns exactly
// one output word with the level and phase after the event. The block takes a
// word every cycle unless the output stalls. An accepted word sits in the
// input register while the rate multiplier and the compare and clamp logic
// form the next envelope state; the envelope state register, loaded when the
// word advances, also serves as the output register. A stalled output word
// holds the state, so at most two words are inside the block and the input
// stalls only while both slots are full and the output is stalled. The state
// loop, one 16x16 multiply and a 33-bit compare, sets the clock. Configuration
// registers (attack_rate, decay_rate, sustain_level, release_rate at indexes
// 0..3) are written through cfg_we/cfg_index/cfg_data and must only change
// while no word is in flight.
module adsr_envelope_generator #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    // configuration write port
    input  logic                                    cfg_we,
    input  logic [adsr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]      cfg_data,

    // input word channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    command,
    input  logic                                    gate_on,
    input  logic [adsr_pkg::DT_BITS-1:0]            elapsed,

    // output word channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [adsr_pkg::LEVEL_OUT_BITS-1:0]     level,
    output logic [adsr_pkg::PHASE_BITS-1:0]         phase
);

    adsr_pkg::cfg_t         cfg;

    // input register
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    adsr_pkg::evt_t         s1_evt_reg;
    logic                   in_take;

    // output word valid; the envelope state is its payload
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   s1_move;

    logic [LEVEL_BITS-1:0]  env_level;
    adsr_pkg::phase_t       env_phase;

    adsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // word in the input register advances when the output slot is free or draining
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_evt_reg.command <= command;
            s1_evt_reg.gate_on <= gate_on;
            s1_evt_reg.elapsed <= elapsed;
        end
    end

    // envelope state update, one word per cycle while the output is not stalled
    adsr_step #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (s1_move),
        .ev    (s1_evt_reg),
        .cfg   (cfg),
        .level (env_level),
        .phase (env_phase)
    );

    assign out_valid = out_valid_reg;
    assign level     = adsr_pkg::LEVEL_OUT_BITS'(env_level);
    assign phase     = env_phase;

    // every word that leaves the input register shows up as an output word
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("output word lost after state update");

    // input side only stalls with a word parked in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked word");

    // a taken output word with nothing behind it clears the output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !s1_move) |=> !out_valid_reg)
        else $error("output word repeated");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    // predictor width, matches the instance below
    localparam int          ENV_BITS    = 16;
    localparam logic [32:0] FULL_SCALE  = (33'd1 << ENV_BITS) - 33'd1;
    // extra quiet cycles after the block has drained
    localparam int          DRAIN_SLACK = 4;
    localparam int          LONG_HOLD   = 240;
    localparam int          CYCLE_LIMIT = 400000;

    // level and phase after one event
    typedef struct packed {
        logic [adsr_pkg::LEVEL_OUT_BITS-1:0] level;
        adsr_pkg::phase_t                    phase;
    } env_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, known from time zero
    logic                               cfg_we    = 1'b0;
    logic [adsr_pkg::CFG_IDX_BITS-1:0]  cfg_index = adsr_pkg::CFG_ATTACK_RATE;
    logic [adsr_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                               in_valid  = 1'b0;
    logic                               command   = adsr_pkg::CMD_TICK;
    logic                               gate_on   = 1'b0;
    logic [adsr_pkg::DT_BITS-1:0]       elapsed   = '0;
    logic                               out_stall = 1'b0;

    // block outputs
    logic                                in_stall;
    logic                                out_valid;
    logic [adsr_pkg::LEVEL_OUT_BITS-1:0] level;
    logic [adsr_pkg::PHASE_BITS-1:0]     phase;

    // words waiting to be offered and results still owed by the block
    adsr_pkg::evt_t pending_words[$];
    env_result_t    expected_env[$];

    // predictor copy of the registers and of the envelope state
    adsr_pkg::cfg_t                      shadow_cfg = '{adsr_pkg::RST_ATTACK_RATE,
                                                        adsr_pkg::RST_DECAY_RATE,
                                                        adsr_pkg::RST_SUSTAIN_LEVEL,
                                                        adsr_pkg::RST_RELEASE_RATE};
    logic [adsr_pkg::LEVEL_OUT_BITS-1:0] env_lvl    = '0;
    adsr_pkg::phase_t                    env_ph     = adsr_pkg::PH_RELEASE;

    // idling knobs, set per phase by the sequence below
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_requests  = 0;

    // random sequence state: gate the script believes is applied, ticks left
    logic gate_is_on = 1'b0;
    int   ticks_left = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    always #6 clk = ~clk;

    adsr_envelope_generator #(
        .LEVEL_BITS (ENV_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .gate_on   (gate_on),
        .elapsed   (elapsed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level),
        .phase     (phase)
    );

    // one event through the envelope: gate moves the phase only, tick
    // advances the current phase by rate*elapsed with the clamps
    function automatic env_result_t advance_envelope(input adsr_pkg::evt_t w);
        logic [32:0] prod;
        logic [32:0] lvl;
        logic [32:0] sus;
        env_result_t r;
        lvl  = {17'd0, env_lvl};
        sus  = {17'd0, shadow_cfg.sustain_level};
        // sustain never above full scale (only bites for narrow levels)
        if (sus > FULL_SCALE)
            sus = FULL_SCALE;
        prod = '0;
        if (w.command == adsr_pkg::CMD_GATE)
        begin
            env_ph = w.gate_on ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_RELEASE;
        end
        else
        begin
            case (env_ph)
                adsr_pkg::PH_ATTACK:
                begin
                    prod = 33'(shadow_cfg.attack_rate) * 33'(w.elapsed);
                    // saturate at full scale, also for a zero step at full scale
                    if (prod >= FULL_SCALE || lvl >= FULL_SCALE - prod)
                    begin
                        lvl    = FULL_SCALE;
                        env_ph = adsr_pkg::PH_DECAY;
                    end
                    else
                        lvl = lvl + prod;
                end
                adsr_pkg::PH_DECAY:
                begin
                    prod = 33'(shadow_cfg.decay_rate) * 33'(w.elapsed);
                    // at or below sustain, or stepping onto it: settle there
                    if (lvl <= sus || lvl - sus <= prod)
                    begin
                        lvl    = sus;
                        env_ph = adsr_pkg::PH_SUSTAIN;
                    end
                    else
                        lvl = lvl - prod;
                end
                adsr_pkg::PH_SUSTAIN:
                    lvl = sus;
                default:
                begin
                    prod = 33'(shadow_cfg.release_rate) * 33'(w.elapsed);
                    if (lvl <= prod)
                        lvl = '0;
                    else
                        lvl = lvl - prod;
                end
            endcase
        end
        env_lvl = lvl[adsr_pkg::LEVEL_OUT_BITS-1:0];
        r.level = env_lvl;
        r.phase = env_ph;
        return r;
    endfunction

    // driver: offers queued words, holds a stalled word, predicts on accept
    always @(posedge clk or negedge rst_n)
    begin : word_driver
        adsr_pkg::evt_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command  <= adsr_pkg::CMD_TICK;
            gate_on  <= 1'b0;
            elapsed  <= '0;
        end
        else
        begin
            // payload still holds the word taken at this edge
            if (in_valid && !in_stall)
            begin
                w.command = command;
                w.gate_on = gate_on;
                w.elapsed = elapsed;
                expected_env.push_back(advance_envelope(w));
            end
            // only move on once the current word is gone
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w        = pending_words.pop_front();
                    in_valid <= 1'b1;
                    command  <= w.command;
                    gate_on  <= w.gate_on;
                    elapsed  <= w.elapsed;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, or a long hold-off counted down here
    always @(posedge clk or negedge rst_n)
    begin : result_receiver
        int hold_left;
        int holds_served;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_left    = 0;
            holds_served = 0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served = holds_served + 1;
            hold_left    = LONG_HOLD;
            out_stall    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: every accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        env_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_env.size() == 0)
            begin
                $error("unexpected result word: level %0d phase %0d", level, phase);
                mismatches = mismatches + 1;
            end
            else
            begin
                exp_r = expected_env.pop_front();
                if (level !== exp_r.level)
                begin
                    $error("level: expected %0d, got %0d", exp_r.level, level);
                    mismatches = mismatches + 1;
                end
                if (phase !== exp_r.phase)
                begin
                    $error("phase: expected %0d, got %0d", exp_r.phase, phase);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_word(input logic cmd, input logic gate,
                              input logic [adsr_pkg::DT_BITS-1:0] dt);
        adsr_pkg::evt_t w;
        w.command = cmd;
        w.gate_on = gate;
        w.elapsed = dt;
        pending_words.push_back(w);
    endtask

    // mostly gate/tick scripts with random content, some pure noise
    task automatic queue_random_words(input int count);
        adsr_pkg::evt_t w;
        int             k;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 15)
            begin
                w.command = 1'($urandom_range(1));
                w.gate_on = 1'($urandom_range(1));
                w.elapsed = adsr_pkg::DT_BITS'($urandom);
            end
            else if (ticks_left == 0)
            begin
                // mostly toggle the gate, now and then retrigger the same value
                w.command  = adsr_pkg::CMD_GATE;
                w.gate_on  = ($urandom_range(9) == 0) ? gate_is_on : !gate_is_on;
                w.elapsed  = adsr_pkg::DT_BITS'($urandom);
                gate_is_on = w.gate_on;
                ticks_left = int'($urandom_range(12, 1));
            end
            else
            begin
                w.command = adsr_pkg::CMD_TICK;
                w.gate_on = 1'($urandom_range(1));
                case ($urandom_range(9))
                    0, 1, 2, 3: w.elapsed = adsr_pkg::DT_BITS'($urandom_range(7));
                    4, 5, 6:    w.elapsed = adsr_pkg::DT_BITS'($urandom_range(255));
                    7, 8:       w.elapsed = adsr_pkg::DT_BITS'($urandom);
                    default:    w.elapsed = $urandom_range(1) ? '1 : '0;
                endcase
                ticks_left = ticks_left - 1;
            end
            pending_words.push_back(w);
        end
    endtask

    // everything offered, taken and answered, then a few quiet cycles
    task automatic wait_until_drained();
        while (pending_words.size() != 0 || in_valid || expected_env.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    task automatic write_reg(input logic [adsr_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [adsr_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    // only called with the block idle, so the shadow copy can move at once
    task automatic program_regs(input logic [adsr_pkg::RATE_BITS-1:0] atk,
                                input logic [adsr_pkg::RATE_BITS-1:0] dcy,
                                input logic [adsr_pkg::RATE_BITS-1:0] sus,
                                input logic [adsr_pkg::RATE_BITS-1:0] rel);
        write_reg(adsr_pkg::CFG_ATTACK_RATE, atk);
        write_reg(adsr_pkg::CFG_DECAY_RATE, dcy);
        write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, sus);
        write_reg(adsr_pkg::CFG_RELEASE_RATE, rel);
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_cfg.attack_rate   = atk;
        shadow_cfg.decay_rate    = dcy;
        shadow_cfg.sustain_level = sus;
        shadow_cfg.release_rate  = rel;
    endtask

    initial
    begin : sequence_main
        int ph;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: release floor, ignored fields, attack and decay
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd0);
        queue_word(adsr_pkg::CMD_TICK, 1'b1, 16'hffff);
        queue_word(adsr_pkg::CMD_GATE, 1'b1, 16'hffff);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd0);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd10);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'hffff);
        // retrigger at full scale, zero step must still move to decay
        queue_word(adsr_pkg::CMD_GATE, 1'b1, 16'd0);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd0);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd1);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd100);
        wait_until_drained();

        // sustain raised above the decaying level: jumps up into sustain
        program_regs(adsr_pkg::RST_ATTACK_RATE, adsr_pkg::RST_DECAY_RATE, 16'hffff,
                     adsr_pkg::RST_RELEASE_RATE);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd0);
        queue_word(adsr_pkg::CMD_TICK, 1'b1, 16'd5);
        queue_word(adsr_pkg::CMD_GATE, 1'b0, 16'd1234);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'hffff);
        wait_until_drained();

        // exact landings: full scale in attack, sustain in decay, zero in release
        program_regs(16'hffff, 16'd1, 16'd1000, 16'd1);
        queue_word(adsr_pkg::CMD_GATE, 1'b1, 16'd0);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd1);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd64535);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'hffff);
        queue_word(adsr_pkg::CMD_GATE, 1'b0, 16'hffff);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd999);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd1);
        queue_word(adsr_pkg::CMD_TICK, 1'b0, 16'd0);
        wait_until_drained();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: program_regs(adsr_pkg::RST_ATTACK_RATE, adsr_pkg::RST_DECAY_RATE,
                                adsr_pkg::RST_SUSTAIN_LEVEL, adsr_pkg::RST_RELEASE_RATE);
                1: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
                2: program_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff);
                4, 7: program_regs(adsr_pkg::RATE_BITS'($urandom_range(64, 1)),
                                   adsr_pkg::RATE_BITS'($urandom_range(16, 1)),
                                   adsr_pkg::RATE_BITS'($urandom),
                                   adsr_pkg::RATE_BITS'($urandom_range(16, 1)));
                6: program_regs(16'hffff, 16'd0, 16'd0, 16'hffff);
                default: program_regs(adsr_pkg::RATE_BITS'($urandom),
                                      adsr_pkg::RATE_BITS'($urandom),
                                      adsr_pkg::RATE_BITS'($urandom),
                                      adsr_pkg::RATE_BITS'($urandom));
            endcase

            // idling pattern rotates: none, sender, receiver, both
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase

            queue_random_words(60);
            // long receiver hold-off while the sender keeps offering words
            if (ph == 0)
                hold_requests = hold_requests + 1;
            // sender pauses until every owed result is back
            wait_until_drained();
            queue_random_words(60);
            wait_until_drained();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
